>>> rtl/psp_pkg.sv
// Shared constants, types and a helper function for the Pauli string product pipeline.
package psp_pkg;

    localparam int QUBITS       = 16;
    localparam int FIELD_QUBITS = 16;
    localparam int NQ           = (QUBITS > FIELD_QUBITS) ? FIELD_QUBITS : QUBITS;
    localparam int OPS_W        = 2 * FIELD_QUBITS;
    localparam int COEF_W       = 16;
    localparam int FRAC_BITS    = 13;
    localparam int MUL_W        = 2 * COEF_W;
    localparam int SUM_W        = MUL_W + 1;
    localparam int ROT_W        = SUM_W + 1;
    localparam int RND_W        = ROT_W + 1 - FRAC_BITS;
    localparam int PHASE_W      = 2;
    localparam int CNT_W        = $clog2(FIELD_QUBITS + 1);

    localparam int S_TDATA_W    = OPS_W * 2 + COEF_W * 4;
    localparam int M_FIELDS_W   = OPS_W + COEF_W * 2 + 2;
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        PAULI_I = 2'd0,
        PAULI_X = 2'd1,
        PAULI_Y = 2'd2,
        PAULI_Z = 2'd3
    } pauli_t;

    typedef enum logic [PHASE_W-1:0] {
        PHASE_ONE    = 2'd0,
        PHASE_POS_I  = 2'd1,
        PHASE_NEG    = 2'd2,
        PHASE_NEG_I  = 2'd3
    } phase_t;

    // Cyclic successor in the order X -> Y -> Z -> X
    function automatic pauli_t pauli_next(input pauli_t p);
        pauli_t r;
        case (p)
            PAULI_X: r = PAULI_Y;
            PAULI_Y: r = PAULI_Z;
            PAULI_Z: r = PAULI_X;
            default: r = PAULI_I;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic [OPS_W-1:0]        ops;
        phase_t                  phase;
        logic signed [MUL_W-1:0] rr;
        logic signed [MUL_W-1:0] ii;
        logic signed [MUL_W-1:0] ri;
        logic signed [MUL_W-1:0] ir;
    } s1_t;

    typedef struct packed {
        logic [OPS_W-1:0]        ops;
        phase_t                  phase;
        logic signed [SUM_W-1:0] re;
        logic signed [SUM_W-1:0] im;
    } s2_t;

    typedef struct packed {
        logic [OPS_W-1:0]        ops;
        logic signed [RND_W-1:0] re;
        logic signed [RND_W-1:0] im;
    } s3_t;

    typedef struct packed {
        logic [OPS_W-1:0]         ops;
        logic signed [COEF_W-1:0] re;
        logic signed [COEF_W-1:0] im;
        logic                     identity_flag;
        logic                     saturated;
    } s4_t;

endpackage

>>> rtl/psp_phase.sv
// Per-qubit operator XOR and phase accumulation of the two strings.
module psp_phase (
    input  logic [psp_pkg::OPS_W-1:0] a_ops,
    input  logic [psp_pkg::OPS_W-1:0] b_ops,
    output logic [psp_pkg::OPS_W-1:0] prod_ops,
    output psp_pkg::phase_t           phase
);
    import psp_pkg::*;

    logic [FIELD_QUBITS-1:0] plus_vec;
    logic [FIELD_QUBITS-1:0] minus_vec;
    logic [CNT_W-1:0]        plus_cnt;
    logic [CNT_W-1:0]        minus_cnt;
    logic [CNT_W-1:0]        diff;

    for (genvar q = 0; q < FIELD_QUBITS; q++) begin : g_qubit
        if (q < NQ) begin : g_live
            pauli_t a_op;
            pauli_t b_op;
            logic   anti;
            assign a_op = pauli_t'(a_ops[2*q +: 2]);
            assign b_op = pauli_t'(b_ops[2*q +: 2]);
            assign anti = (a_op != PAULI_I) && (b_op != PAULI_I) && (a_op != b_op);
            assign plus_vec[q]  = anti && (b_op == pauli_next(a_op));
            assign minus_vec[q] = anti && (b_op != pauli_next(a_op));
            assign prod_ops[2*q +: 2] = a_ops[2*q +: 2] ^ b_ops[2*q +: 2];
        end else begin : g_dead
            // qubits beyond the string length read as identity
            assign plus_vec[q]  = 1'b0;
            assign minus_vec[q] = 1'b0;
            assign prod_ops[2*q +: 2] = PAULI_I;
        end
    end

    assign plus_cnt  = CNT_W'($countones(plus_vec));
    assign minus_cnt = CNT_W'($countones(minus_vec));
    // +i counts once, -i counts as three quarter turns: net turns mod 4
    assign diff      = plus_cnt - minus_cnt;
    assign phase     = phase_t'(diff[PHASE_W-1:0]);

endmodule

>>> rtl/psp_rnd.sv
// Rotation of the exact complex product by a power of i, then rounding to Q2.13.
module psp_rnd (
    input  psp_pkg::phase_t                  phase,
    input  logic signed [psp_pkg::SUM_W-1:0] re_in,
    input  logic signed [psp_pkg::SUM_W-1:0] im_in,
    output logic signed [psp_pkg::RND_W-1:0] re_out,
    output logic signed [psp_pkg::RND_W-1:0] im_out
);
    import psp_pkg::*;

    localparam logic signed [ROT_W:0] HALF_LSB = (ROT_W + 1)'(1) << (FRAC_BITS - 1);

    logic signed [ROT_W-1:0] re_w;
    logic signed [ROT_W-1:0] im_w;
    logic signed [ROT_W-1:0] re_rot;
    logic signed [ROT_W-1:0] im_rot;
    logic signed [ROT_W:0]   re_biased;
    logic signed [ROT_W:0]   im_biased;

    assign re_w = ROT_W'(re_in);
    assign im_w = ROT_W'(im_in);

    always_comb begin
        case (phase)
            PHASE_POS_I: begin
                re_rot = -im_w;
                im_rot = re_w;
            end
            PHASE_NEG: begin
                re_rot = -re_w;
                im_rot = -im_w;
            end
            PHASE_NEG_I: begin
                re_rot = im_w;
                im_rot = -re_w;
            end
            default: begin
                re_rot = re_w;
                im_rot = im_w;
            end
        endcase
    end

    // add half an LSB and floor: ties go toward plus infinity
    assign re_biased = (ROT_W + 1)'(re_rot) + HALF_LSB;
    assign im_biased = (ROT_W + 1)'(im_rot) + HALF_LSB;
    assign re_out    = RND_W'(re_biased >>> FRAC_BITS);
    assign im_out    = RND_W'(im_biased >>> FRAC_BITS);

endmodule

>>> rtl/psp_sat.sv
// Saturation to 16 bits and result flags.
module psp_sat (
    input  psp_pkg::s3_t stage_in,
    output psp_pkg::s4_t stage_out
);
    import psp_pkg::*;

    localparam logic signed [RND_W-1:0] MAX_V = RND_W'((1 << (COEF_W - 1)) - 1);
    localparam logic signed [RND_W-1:0] MIN_V = -RND_W'(1 << (COEF_W - 1));

    logic signed [COEF_W-1:0] re_c;
    logic signed [COEF_W-1:0] im_c;
    logic                     re_sat;
    logic                     im_sat;

    always_comb begin
        re_sat = 1'b1;
        im_sat = 1'b1;
        if (stage_in.re > MAX_V) begin
            re_c = MAX_V[COEF_W-1:0];
        end else if (stage_in.re < MIN_V) begin
            re_c = MIN_V[COEF_W-1:0];
        end else begin
            re_c   = stage_in.re[COEF_W-1:0];
            re_sat = 1'b0;
        end
        if (stage_in.im > MAX_V) begin
            im_c = MAX_V[COEF_W-1:0];
        end else if (stage_in.im < MIN_V) begin
            im_c = MIN_V[COEF_W-1:0];
        end else begin
            im_c   = stage_in.im[COEF_W-1:0];
            im_sat = 1'b0;
        end
    end

    assign stage_out.ops           = stage_in.ops;
    assign stage_out.re            = re_c;
    assign stage_out.im            = im_c;
    assign stage_out.identity_flag = (stage_in.ops == '0) && ((re_c != '0) || (im_c != '0));
    assign stage_out.saturated     = re_sat || im_sat;

endmodule

>>> rtl/pauli_string_product.sv
// Top level of the Pauli string product pipeline.
// Multiplies two weighted Pauli strings (16 qubits, 2 bits each, Q2.13 complex
// coefficients) and returns the product string, its rounded and saturated
// coefficient and two flags. Four register stages: four 16x16 multiplies and
// the per-qubit phase count, the complex add, rotation by i^phase with
// rounding, then saturation into the output register. A request is accepted
// every cycle while s_axis_tready is high, and m_axis_tvalid is the valid bit of
// the output register. The ready path runs combinationally from m_axis_tready
// back through the stage valids, so any stage bubble is filled while the
// output is stalled.
module pauli_string_product (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // a_ops[31:0], b_ops[63:32], a_re[79:64], a_im[95:80], b_re[111:96], b_im[127:112]
    input  logic [psp_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // prod_ops[31:0], prod_re[47:32], prod_im[63:48], identity_flag[64], saturated[65], zero pad
    output logic [psp_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import psp_pkg::*;

    logic [OPS_W-1:0]         a_ops;
    logic [OPS_W-1:0]         b_ops;
    logic signed [COEF_W-1:0] a_re;
    logic signed [COEF_W-1:0] a_im;
    logic signed [COEF_W-1:0] b_re;
    logic signed [COEF_W-1:0] b_im;

    s1_t s1_next, s1_reg;
    s2_t s2_next, s2_reg;
    s3_t s3_next, s3_reg;
    s4_t s4_next, s4_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign a_ops = s_axis_tdata[0 +: OPS_W];
    assign b_ops = s_axis_tdata[OPS_W +: OPS_W];
    assign a_re  = s_axis_tdata[2*OPS_W +: COEF_W];
    assign a_im  = s_axis_tdata[2*OPS_W + COEF_W +: COEF_W];
    assign b_re  = s_axis_tdata[2*OPS_W + 2*COEF_W +: COEF_W];
    assign b_im  = s_axis_tdata[2*OPS_W + 3*COEF_W +: COEF_W];

    // a stage may load when it is empty or its content moves on this cycle
    assign rdy4 = !v4_reg || m_axis_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    // stage 1: partial products and phase
    psp_phase u_phase (
        .a_ops    (a_ops),
        .b_ops    (b_ops),
        .prod_ops (s1_next.ops),
        .phase    (s1_next.phase)
    );

    assign s1_next.rr = MUL_W'(a_re * b_re);
    assign s1_next.ii = MUL_W'(a_im * b_im);
    assign s1_next.ri = MUL_W'(a_re * b_im);
    assign s1_next.ir = MUL_W'(a_im * b_re);

    // stage 2: complex combine
    assign s2_next.ops   = s1_reg.ops;
    assign s2_next.phase = s1_reg.phase;
    assign s2_next.re    = SUM_W'(s1_reg.rr) - SUM_W'(s1_reg.ii);
    assign s2_next.im    = SUM_W'(s1_reg.ri) + SUM_W'(s1_reg.ir);

    // stage 3: rotate and round
    assign s3_next.ops = s2_reg.ops;

    psp_rnd u_rnd (
        .phase  (s2_reg.phase),
        .re_in  (s2_reg.re),
        .im_in  (s2_reg.im),
        .re_out (s3_next.re),
        .im_out (s3_next.im)
    );

    // stage 4: saturate and flag
    psp_sat u_sat (
        .stage_in  (s3_reg),
        .stage_out (s4_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_axis_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_axis_tvalid) begin
            s1_reg <= s1_next;
        end
        if (rdy2 && v1_reg) begin
            s2_reg <= s2_next;
        end
        if (rdy3 && v2_reg) begin
            s3_reg <= s3_next;
        end
        if (rdy4 && v3_reg) begin
            s4_reg <= s4_next;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = M_TDATA_W'({s4_reg.saturated, s4_reg.identity_flag,
                                       s4_reg.im, s4_reg.re, s4_reg.ops});

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for pauli_string_product: directed and random term pairs.
module tb_top;
    import psp_pkg::*;

    localparam int          RANDOM_PAIRS = 1700;
    localparam int          DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam longint      COEF_MAX     = (longint'(1) <<< (COEF_W - 1)) - 1;
    localparam longint      COEF_MIN     = -(COEF_MAX + 1);
    localparam longint      HALF_LSB     = longint'(1) <<< (FRAC_BITS - 1);
    localparam int          ONE          = 1 << FRAC_BITS;

    // Field order matches s_axis_tdata, highest bits first
    typedef struct packed {
        logic signed [COEF_W-1:0] b_im;
        logic signed [COEF_W-1:0] b_re;
        logic signed [COEF_W-1:0] a_im;
        logic signed [COEF_W-1:0] a_re;
        logic [OPS_W-1:0]         b_ops;
        logic [OPS_W-1:0]         a_ops;
    } term_pair_t;

    // Field order matches m_axis_tdata below the zero pad
    typedef struct packed {
        logic                     saturated;
        logic                     identity_flag;
        logic signed [COEF_W-1:0] im;
        logic signed [COEF_W-1:0] re;
        logic [OPS_W-1:0]         ops;
    } term_prod_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_TRICKLE, RX_COMB} rx_mode_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    term_pair_t  pending_pairs[$];
    term_prod_t  expected_prods[$];
    term_prod_t  got_prod, want_prod;
    int unsigned burst_left = 0, gap_left = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int unsigned rx_span = 0, rx_tick = 0;
    int unsigned cycle_count = 0;
    int unsigned n_errors = 0, n_checked = 0, n_saturated = 0, n_identity = 0;
    int unsigned n_directed = 0;

    pauli_string_product dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic signed [COEF_W-1:0] clip_coef(input longint v, inout logic sat);
        if (v > COEF_MAX) begin
            sat = 1'b1;
            return COEF_MAX[COEF_W-1:0];
        end
        if (v < COEF_MIN) begin
            sat = 1'b1;
            return COEF_MIN[COEF_W-1:0];
        end
        return v[COEF_W-1:0];
    endfunction

    function automatic term_prod_t multiply_terms(input term_pair_t t);
        term_prod_t p;
        pauli_t     pa, pb;
        logic [1:0] ph;
        longint     re, im, tmp;
        logic       sat;
        p   = '0;
        ph  = '0;
        sat = 1'b0;
        for (int q = 0; q < NQ; q++) begin
            pa = pauli_t'(t.a_ops[2*q +: 2]);
            pb = pauli_t'(t.b_ops[2*q +: 2]);
            if (pa != PAULI_I && pb != PAULI_I && pa != pb) begin
                if ((pa == PAULI_X && pb == PAULI_Y) || (pa == PAULI_Y && pb == PAULI_Z) ||
                    (pa == PAULI_Z && pb == PAULI_X)) begin
                    ph = ph + PHASE_POS_I;
                end else begin
                    ph = ph + PHASE_NEG_I;
                end
            end
            p.ops[2*q +: 2] = pa ^ pb;
        end
        re = longint'(t.a_re) * longint'(t.b_re) - longint'(t.a_im) * longint'(t.b_im);
        im = longint'(t.a_re) * longint'(t.b_im) + longint'(t.a_im) * longint'(t.b_re);
        case (phase_t'(ph))
            PHASE_POS_I: begin
                tmp = re;
                re  = -im;
                im  = tmp;
            end
            PHASE_NEG: begin
                re = -re;
                im = -im;
            end
            PHASE_NEG_I: begin
                tmp = re;
                re  = im;
                im  = -tmp;
            end
            default: ;
        endcase
        // round half up: arithmetic shift floors
        p.re = clip_coef((re + HALF_LSB) >>> FRAC_BITS, sat);
        p.im = clip_coef((im + HALF_LSB) >>> FRAC_BITS, sat);
        p.identity_flag = (p.ops == '0) && (p.re != 0 || p.im != 0);
        p.saturated     = sat;
        return p;
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef();
        logic [31:0] r;
        int          v;
        r = $urandom;
        case ($urandom_range(0, 5))
            0, 1: v = int'(r[COEF_W-1:0]);
            2: v = $urandom_range(0, 2047) - 1024;
            3: begin
                case ($urandom_range(0, 4))
                    0: v = int'(COEF_MIN);
                    1: v = int'(COEF_MAX);
                    2: v = -ONE;
                    3: v = 1;
                    default: v = -1;
                endcase
            end
            4: v = (r[31] ? -ONE : ONE) + $urandom_range(0, 64) - 32;
            default: v = 0;
        endcase
        return v[COEF_W-1:0];
    endfunction

    task automatic add_pair(input logic [OPS_W-1:0] ao, input logic [OPS_W-1:0] bo,
                            input int ar, input int ai, input int br, input int bi);
        term_pair_t t;
        t.a_ops = ao;
        t.b_ops = bo;
        t.a_re  = ar[COEF_W-1:0];
        t.a_im  = ai[COEF_W-1:0];
        t.b_re  = br[COEF_W-1:0];
        t.b_im  = bi[COEF_W-1:0];
        pending_pairs.push_back(t);
    endtask

    // Request driver: bursts of back-to-back requests separated by random gaps, sometimes none
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left != 0 || pending_pairs.size() == 0) begin
                if (gap_left != 0) begin
                    gap_left--;
                end
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tdata  <= pending_pairs.pop_front();
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // Result sink: stall pattern switches at random between four modes
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_span == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_span = $urandom_range(16, 256);
            end else begin
                rx_span--;
            end
            rx_tick++;
            case (rx_mode)
                RX_OPEN:    m_axis_tready <= 1'b1;
                RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
                RX_TRICKLE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:    m_axis_tready <= (rx_tick % 5) < 3;
            endcase
        end
    end

    // Monitor: predict on each accepted request, check each accepted result
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_prod = term_prod_t'(m_axis_tdata[M_FIELDS_W-1:0]);
                if (expected_prods.size() == 0) begin
                    $error("result %h with no request outstanding", m_axis_tdata);
                    n_errors++;
                end else begin
                    want_prod = expected_prods.pop_front();
                    if (got_prod.ops !== want_prod.ops) begin
                        $error("prod_ops: expected %h, got %h", want_prod.ops, got_prod.ops);
                        n_errors++;
                    end
                    if (got_prod.re !== want_prod.re) begin
                        $error("prod_re: expected %0d, got %0d", want_prod.re, got_prod.re);
                        n_errors++;
                    end
                    if (got_prod.im !== want_prod.im) begin
                        $error("prod_im: expected %0d, got %0d", want_prod.im, got_prod.im);
                        n_errors++;
                    end
                    if (got_prod.identity_flag !== want_prod.identity_flag) begin
                        $error("identity_flag: expected %b, got %b",
                               want_prod.identity_flag, got_prod.identity_flag);
                        n_errors++;
                    end
                    if (got_prod.saturated !== want_prod.saturated) begin
                        $error("saturated: expected %b, got %b",
                               want_prod.saturated, got_prod.saturated);
                        n_errors++;
                    end
                    n_checked++;
                    n_saturated += want_prod.saturated;
                    n_identity  += want_prod.identity_flag;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_prods.push_back(multiply_terms(term_pair_t'(s_axis_tdata)));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [OPS_W-1:0] combo_a, combo_b;
        term_pair_t       t;
        int               q;

        // all-identity strings: zero coefficient, unity, and one that rounds to zero
        add_pair('0, '0, 0, 0, 0, 0);
        add_pair('0, '0, ONE, 0, ONE, 0);
        add_pair('0, '0, 1, 0, 1, 0);
        // every anticommuting pair on the lowest qubit, complex coefficient to expose rotation
        for (int a = 1; a < 4; a++) begin
            for (int b = 1; b < 4; b++) begin
                if (a != b) begin
                    add_pair(a, b, ONE, ONE / 2, ONE, 0);
                end
            end
        end
        // top qubit
        add_pair({PAULI_X, 30'd0}, {PAULI_Y, 30'd0}, ONE, ONE / 2, ONE, 0);
        add_pair({PAULI_Z, 30'd0}, {PAULI_Y, 30'd0}, ONE, ONE / 2, ONE, 0);
        // all sixteen operator pairs at once, one per qubit
        combo_a = '0;
        combo_b = '0;
        for (q = 0; q < 16; q++) begin
            combo_a[2*q +: 2] = 2'(q >> 2);
            combo_b[2*q +: 2] = 2'(q & 3);
        end
        add_pair(combo_a, combo_b, ONE, -ONE, -ONE / 2, ONE / 4);
        // saturating extremes
        add_pair('1, {16{PAULI_X}}, -32768, -32768, -32768, -32768);
        add_pair({16{PAULI_Y}}, {16{PAULI_Y}}, 32767, 32767, 32767, -32768);
        add_pair({24'd0, PAULI_X, 6'd0}, {24'd0, PAULI_Y, 6'd0}, -32768, 0, -32768, 0);
        add_pair('0, '0, 32767, 0, -32768, 0);
        add_pair('1, '1, -32768, 0, -32768, 0);
        // rounding ties on either sign, and values just past a tie
        add_pair('0, '0, 1, 0, ONE / 2, 0);
        add_pair('0, '0, -1, 0, ONE / 2, 0);
        add_pair('0, '0, -1, 0, ONE / 2 + 1, 0);
        add_pair({16{PAULI_Z}}, '0, 0, 3, 0, ONE / 2 + 1);
        n_directed = pending_pairs.size();

        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            t.a_ops = $urandom;
            case ($urandom_range(0, 7))
                0: t.b_ops = t.a_ops;
                1: begin
                    // differ in at most a single qubit
                    t.b_ops = t.a_ops;
                    q = $urandom_range(0, 15);
                    t.b_ops[2*q +: 2] = 2'($urandom_range(0, 3));
                end
                2: t.b_ops = '0;
                3: begin
                    t.a_ops = '0;
                    t.b_ops = $urandom;
                end
                default: t.b_ops = $urandom;
            endcase
            t.a_re = rand_coef();
            t.a_im = rand_coef();
            t.b_re = rand_coef();
            t.b_im = rand_coef();
            pending_pairs.push_back(t);
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        do begin
            @(posedge aclk);
        end while (pending_pairs.size() != 0 || s_axis_tvalid || expected_prods.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d products (%0d directed, %0d random requests) in %0d cycles",
                 n_checked, n_directed, RANDOM_PAIRS, cycle_count);
        $display("Of these %0d saturated and %0d reduced to a nonzero identity",
                 n_saturated, n_identity);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/psp_pkg.sv
rtl/psp_phase.sv
rtl/psp_rnd.sv
rtl/psp_sat.sv
rtl/pauli_string_product.sv
sim/tb_top.sv
